// File: sv/eink_frame_timing_sequencer_top_assert.svh
// Assertion macros used by the frame timing sequencer top module.
`ifndef EINK_FRAME_TIMING_SEQUENCER_TOP_ASSERT_SVH
`define EINK_FRAME_TIMING_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define EFTSEQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eftseq assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define EFTSEQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eftseq assertion failed");

`endif

// File: sv/eftseq_pkg.sv
// Types and constants shared by the frame timing sequencer modules.
`timescale 1ns / 1ps

package eftseq_pkg;

	localparam int PAT_W = 16;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_STV     = 4'd1,
		PH_STV_CKV = 4'd2,
		PH_FGAP    = 4'd3,
		PH_STH     = 4'd4,
		PH_STH_CKH = 4'd5,
		PH_LGAP    = 4'd6,
		PH_BHI     = 4'd7,
		PH_BLO     = 4'd8,
		PH_LEH     = 4'd9,
		PH_LEH_GAP = 4'd10,
		PH_CKV     = 4'd11,
		PH_CKV_GAP = 4'd12,
		PH_DONE    = 4'd13
	} phase_t;

	typedef enum logic [1:0] {
		REG_LINE_COUNT       = 2'd0,
		REG_CLOCKS_PER_LINE  = 2'd1,
		REG_PHASE_TICKS      = 2'd2,
		REG_BURST_HALF_TICKS = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [11:0] line_count;
		logic [9:0]  clocks_per_line;
		logic [15:0] phase_ticks;
		logic [7:0]  burst_half_ticks;
	} cfg_t;

	typedef struct packed {
		logic             stv;
		logic             ckv;
		logic             sth;
		logic             ckh;
		logic             leh;
		logic [PAT_W-1:0] data_bus;
		logic             bus_drive;
		logic             busy_res;
		logic             frame_done;
	} res_t;

	localparam logic [11:0] LINE_COUNT_RST       = 12'd1500;
	localparam logic [9:0]  CLOCKS_PER_LINE_RST  = 10'd250;
	localparam logic [15:0] PHASE_TICKS_RST      = 16'd200;
	localparam logic [7:0]  BURST_HALF_TICKS_RST = 8'd2;

endpackage

// File: sv/eink_frame_timing_sequencer_top.sv
// The pin levels for a tick are registered and appear on the master side in the cycle after it is accepted.
// Throughput: one tick per cycle while m_axis_tready holds; the single result register refills in the cycle it drains.
// A frame spans many ticks, set by the line, clock, phase tick and burst half tick registers.
// Reset (arst_n low) returns the sequencer to idle, clears the bus latch and loads the
// register defaults of 1500 lines and the CLOCKS_PER_LINE_RST, PHASE_TICKS_RST and BURST_HALF_TICKS_RST values.
`timescale 1ns / 1ps
`include "eink_frame_timing_sequencer_top_assert.svh"

module eink_frame_timing_sequencer_top #(
	parameter int BUS_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side. tdata from bit 0: start_req, pattern[15:0], zero padding.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,
	// Master side. tdata from bit 0: stv, ckv, sth, ckh, leh, data_bus[15:0],
	// bus_drive, busy_res, zero padding. tlast carries frame_done.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast,
	// Configuration write channel; cfg_index selects the register.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import eftseq_pkg::*;

	cfg_t cfg;
	res_t res_d, res_q;
	logic in_accept;
	logic out_valid;

	// A new tick is taken whenever the result register is empty or being drained
	// in the same cycle, so a full stream runs at one tick per cycle while m_axis_tready holds.
	assign s_axis_tready = !out_valid || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	eftseq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_ready (cfg_ready),
		.wr_index (cfg_reg_t'(cfg_index)),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The sequencer state advances by exactly one tick per accepted
	// transaction, and the pin levels it computes go straight to the
	// result register.
	eftseq_core #(
		.BUS_WIDTH (BUS_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (in_accept),
		.start_req (s_axis_tdata[0]),
		.pattern   (s_axis_tdata[PAT_W:1]),
		.cfg       (cfg),
		.res       (res_d)
	);

	eftseq_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (in_accept),
		.res_d      (res_d),
		.take       (m_axis_tready),
		.hold_valid (out_valid),
		.res_q      (res_q)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tlast  = res_q.frame_done;
	assign m_axis_tdata  = {1'b0, res_q.busy_res, res_q.bus_drive, res_q.data_bus,
		res_q.leh, res_q.ckh, res_q.sth, res_q.ckv, res_q.stv};

	// Every accepted tick leaves a result waiting in the next cycle.
	`EFTSEQ_ASSERT_NEXT(a_tick_gives_result, in_accept, m_axis_tvalid)
	// The bus carries a word only while it is driven.
	`EFTSEQ_ASSERT_NOW(a_bus_released_zero, m_axis_tvalid && (m_axis_tdata[20:5] != 16'd0),
		m_axis_tdata[21])
	// The end-of-frame pulse is never flagged while the frame is busy or the bus is driven.
	`EFTSEQ_ASSERT_NOW(a_done_not_busy, m_axis_tvalid && m_axis_tlast,
		!m_axis_tdata[22] && !m_axis_tdata[21])
	// Vertical and horizontal start pulses never overlap.
	`EFTSEQ_ASSERT_NOW(a_start_pulses_apart, m_axis_tvalid,
		!(m_axis_tdata[0] && m_axis_tdata[2]))

endmodule

// File: sv/eftseq_cfg.sv
// Configuration register file of the frame timing sequencer.
`timescale 1ns / 1ps

module eftseq_cfg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_valid,
	output logic                    wr_ready,
	input  eftseq_pkg::cfg_reg_t    wr_index,
	input  logic [15:0]             wr_data,
	output eftseq_pkg::cfg_t        cfg
);
	import eftseq_pkg::*;

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_count       <= LINE_COUNT_RST;
			cfg_q.clocks_per_line  <= CLOCKS_PER_LINE_RST;
			cfg_q.phase_ticks      <= PHASE_TICKS_RST;
			cfg_q.burst_half_ticks <= BURST_HALF_TICKS_RST;
		end else if (wr_valid && wr_ready) begin
			unique case (wr_index)
				REG_LINE_COUNT:       cfg_q.line_count       <= wr_data[11:0];
				REG_CLOCKS_PER_LINE:  cfg_q.clocks_per_line  <= wr_data[9:0];
				REG_PHASE_TICKS:      cfg_q.phase_ticks      <= wr_data[15:0];
				REG_BURST_HALF_TICKS: cfg_q.burst_half_ticks <= wr_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// File: sv/eftseq_core.sv
// Sequencer state and the per-tick next-state and pin-level logic.
`timescale 1ns / 1ps

module eftseq_core #(
	parameter int BUS_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick,
	input  logic                           start_req,
	input  logic [eftseq_pkg::PAT_W-1:0]   pattern,
	input  eftseq_pkg::cfg_t               cfg,
	output eftseq_pkg::res_t               res
);
	import eftseq_pkg::*;

	// Only the low bits that fit both the bus and the pattern field are kept.
	localparam int KEEP_W = (BUS_WIDTH < PAT_W) ? BUS_WIDTH : PAT_W;

	phase_t            ph_q, ph_n;
	logic [11:0]       line_q, line_n, line_inc;
	logic [9:0]        burst_q, burst_n, burst_inc;
	logic [15:0]       tick_q, tick_n, len;
	logic [16:0]       tick_inc;
	logic [KEEP_W-1:0] pat_q, pat_n, latch_q, latch_n;
	logic              active;
	logic [PAT_W-1:0]  bus_word;

	always_comb begin
		ph_n      = ph_q;
		line_n    = line_q;
		burst_n   = burst_q;
		tick_n    = tick_q;
		pat_n     = pat_q;
		latch_n   = latch_q;
		line_inc  = line_q + 12'd1;
		burst_inc = burst_q + 10'd1;
		tick_inc  = {1'b0, tick_q} + 17'd1;
		len       = ((ph_q == PH_BHI) || (ph_q == PH_BLO)) ?
			{8'd0, cfg.burst_half_ticks} : cfg.phase_ticks;

		if (ph_q == PH_IDLE) begin
			if (start_req) begin
				pat_n   = pattern[KEEP_W-1:0];
				ph_n    = PH_STV;
				tick_n  = '0;
				line_n  = '0;
				burst_n = '0;
			end
		end else if (ph_q == PH_DONE) begin
			ph_n   = PH_IDLE;
			tick_n = '0;
		end else if (tick_inc < {1'b0, len}) begin
			tick_n = tick_inc[15:0];
		end else begin
			tick_n = '0;
			case (ph_q)
				PH_LGAP: begin
					ph_n    = PH_BHI;
					latch_n = pat_q;
				end
				PH_BLO: begin
					if (burst_inc >= cfg.clocks_per_line) begin
						burst_n = '0;
						ph_n    = PH_LEH;
					end else begin
						burst_n = burst_inc;
						ph_n    = PH_BHI;
					end
				end
				PH_CKV_GAP: begin
					if (line_inc >= cfg.line_count) begin
						line_n = '0;
						ph_n   = PH_DONE;
					end else begin
						line_n = line_inc;
						ph_n   = PH_STH;
					end
				end
				default: ph_n = phase_t'(4'(ph_q) + 4'd1);
			endcase
		end
	end

	// Pin levels of this tick follow the phase entered on it.
	always_comb begin
		active   = (ph_n >= PH_STV) && (ph_n <= PH_CKV_GAP);
		bus_word = '0;
		if (active) begin
			bus_word[KEEP_W-1:0] = latch_n;
		end
		res.stv        = (ph_n == PH_STV) || (ph_n == PH_STV_CKV);
		res.ckv        = (ph_n == PH_STV_CKV) || (ph_n == PH_CKV);
		res.sth        = (ph_n == PH_STH) || (ph_n == PH_STH_CKH);
		res.ckh        = (ph_n == PH_STH_CKH) || (ph_n == PH_BHI);
		res.leh        = (ph_n == PH_LEH);
		res.data_bus   = bus_word;
		res.bus_drive  = active;
		res.busy_res   = active;
		res.frame_done = (ph_n == PH_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			line_q  <= '0;
			burst_q <= '0;
			tick_q  <= '0;
			pat_q   <= '0;
			latch_q <= '0;
		end else if (tick) begin
			ph_q    <= ph_n;
			line_q  <= line_n;
			burst_q <= burst_n;
			tick_q  <= tick_n;
			pat_q   <= pat_n;
			latch_q <= latch_n;
		end
	end

endmodule

// File: sv/eftseq_out.sv
// Result register that holds one set of pin levels until it is taken.
`timescale 1ns / 1ps

module eftseq_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  eftseq_pkg::res_t res_d,
	input  logic             take,
	output logic             hold_valid,
	output eftseq_pkg::res_t res_q
);
	import eftseq_pkg::*;

	logic valid_q;

	assign hold_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule
